// ===== sv/luhn_pkg.sv =====
// Shared types and constants for the card number Luhn check.
// Depends on nothing; used by the controller, the datapath and the top level.
package luhn_pkg;

  localparam int unsigned CARD_W         = 63;
  localparam int unsigned BIN_W          = 64;
  localparam int unsigned NUM_DIGITS     = 19;
  localparam int unsigned BCD_W          = 4 * NUM_DIGITS;
  localparam int unsigned BITS_PER_CYCLE = 4;
  localparam int unsigned CONV_CYCLES    = BIN_W / BITS_PER_CYCLE;
  localparam int unsigned CONV_CNT_W     = $clog2(CONV_CYCLES);
  localparam int unsigned COUNT_W        = 5;
  localparam int unsigned BRAND_W        = 2;

  localparam logic [BRAND_W-1:0] BRAND_NONE = 2'd0;
  localparam logic [BRAND_W-1:0] BRAND_AMEX = 2'd1;
  localparam logic [BRAND_W-1:0] BRAND_MC   = 2'd2;
  localparam logic [BRAND_W-1:0] BRAND_VISA = 2'd3;

  localparam logic [COUNT_W-1:0] LEN_13 = 5'd13;
  localparam logic [COUNT_W-1:0] LEN_15 = 5'd15;
  localparam logic [COUNT_W-1:0] LEN_16 = 5'd16;

  localparam logic [CARD_W-1:0] MC_LOW      = 63'd5100000000000000;
  localparam logic [CARD_W-1:0] MC_HIGH     = 63'd5599999999999999;
  localparam logic [CARD_W-1:0] VISA13_LOW  = 63'd4000000000000;
  localparam logic [CARD_W-1:0] VISA13_HIGH = 63'd4999999999999;
  localparam logic [CARD_W-1:0] VISA16_LOW  = 63'd4000000000000000;
  localparam logic [CARD_W-1:0] VISA16_HIGH = 63'd4999999999999999;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic digit_step;
    logic finish;
  } luhn_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic bcd_zero;
  } luhn_status_t;

endpackage

// ===== sv/luhn_ctrl.sv =====
// Controller for the card number Luhn check: sequences conversion and digit pass.
// Depends on luhn_pkg; drives the datapath through luhn_cmd_t.
module luhn_ctrl
  import luhn_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  luhn_status_t status,
  output luhn_cmd_t    cmd,
  output logic         busy,
  output logic         done
);

  typedef enum logic [1:0] {
    IDLE,
    CONV,
    DIGIT
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    case (state)
      IDLE:    cmd.load = start;
      CONV:    cmd.conv_step = 1'b1;
      DIGIT: begin
        cmd.digit_step = !status.bcd_zero;
        cmd.finish     = status.bcd_zero;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            state <= CONV;
            busy  <= 1'b1;
          end
        end
        CONV: begin
          if (status.conv_last) begin
            state <= DIGIT;
          end
        end
        DIGIT: begin
          if (status.bcd_zero) begin
            state <= IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== sv/luhn_dp.sv =====
// Datapath for the card number Luhn check: binary-to-BCD shifter, digit pass, result registers.
// Depends on luhn_pkg; commanded by luhn_ctrl.
module luhn_dp
  import luhn_pkg::*;
(
  input  logic                clk,
  input  luhn_cmd_t           cmd,
  input  logic [CARD_W-1:0]   pan,
  output luhn_status_t        status,
  output logic [COUNT_W-1:0]  digit_count,
  output logic                length_ok,
  output logic [BRAND_W-1:0]  brand,
  output logic                luhn_ok
);

  logic [CARD_W-1:0]     num;
  logic [BIN_W-1:0]      bin;
  logic [BCD_W-1:0]      bcd;
  logic [CONV_CNT_W-1:0] conv_cnt;
  logic [COUNT_W-1:0]    digits;
  logic [3:0]            sum;
  logic                  dbl;

  logic [BIN_W-1:0]      bin_next;
  logic [BCD_W-1:0]      bcd_next;
  logic [3:0]            luhn_digit;
  logic [4:0]            twice;
  logic [4:0]            sum_wide;
  logic [3:0]            sum_next;
  logic                  len_ok_c;
  logic [BRAND_W-1:0]    brand_c;

  always_comb begin
    bcd_next = bcd;
    bin_next = bin;
    for (int k = 0; k < BITS_PER_CYCLE; k++) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        if (bcd_next[4*i +: 4] >= 4'd5) begin
          bcd_next[4*i +: 4] = bcd_next[4*i +: 4] + 4'd3;
        end
      end
      {bcd_next, bin_next} = {bcd_next[BCD_W-2:0], bin_next, 1'b0};
    end
  end

  always_comb begin
    twice = {bcd[3:0], 1'b0};
    if (twice > 5'd9) begin
      twice = twice - 5'd9;
    end
    luhn_digit = dbl ? twice[3:0] : bcd[3:0];
    sum_wide   = {1'b0, sum} + {1'b0, luhn_digit};
    if (sum_wide >= 5'd10) begin
      sum_wide = sum_wide - 5'd10;
    end
    sum_next = sum_wide[3:0];
  end

  always_comb begin
    len_ok_c = (digits == LEN_13) || (digits == LEN_15) || (digits == LEN_16);
    if (digits == LEN_15) begin
      brand_c = BRAND_AMEX;
    end else if (num >= MC_LOW && num <= MC_HIGH) begin
      brand_c = BRAND_MC;
    end else if ((num >= VISA13_LOW && num <= VISA13_HIGH) ||
                 (num >= VISA16_LOW && num <= VISA16_HIGH)) begin
      brand_c = BRAND_VISA;
    end else begin
      brand_c = BRAND_NONE;
    end
  end

  assign status.conv_last = (conv_cnt == CONV_CNT_W'(CONV_CYCLES - 1));
  assign status.bcd_zero  = (bcd == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num      <= pan;
      bin      <= {1'b0, pan};
      bcd      <= '0;
      conv_cnt <= '0;
      digits   <= '0;
      sum      <= '0;
      dbl      <= 1'b0;
    end else if (cmd.conv_step) begin
      bin      <= bin_next;
      bcd      <= bcd_next;
      conv_cnt <= conv_cnt + 1'b1;
    end else if (cmd.digit_step) begin
      bcd    <= {4'd0, bcd[BCD_W-1:4]};
      sum    <= sum_next;
      dbl    <= !dbl;
      digits <= digits + 1'b1;
    end
    if (cmd.finish) begin
      digit_count <= digits;
      length_ok   <= len_ok_c;
      brand       <= brand_c;
      luhn_ok     <= (sum == 4'd0);
    end
  end

endmodule

// ===== sv/card_number_luhn_check_core.sv =====
// Top level of the card number Luhn check: digit count, length flag, brand, Luhn flag.
// Depends on luhn_pkg, luhn_ctrl and luhn_dp.
//
// channel  | handshake    | ports
// ---------+--------------+------------------------------------------------
// command  | start / busy | pan
// result   | done strobe  | digit_count, length_ok, brand, luhn_ok
//
// A transaction first shifts the card number from binary to BCD (4 bits a cycle),
// then passes one decimal digit per cycle until the BCD value is zero, and then
// registers the results. The number of significant digits sets the length of the pass.
// Reset is synchronous; it drops busy and done. Results are valid when done is high
// for a single cycle and hold after it; a new start is taken in that same cycle.
module card_number_luhn_check_core
  import luhn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [CARD_W-1:0]  pan,
  output logic               busy,
  output logic               done,
  output logic [COUNT_W-1:0] digit_count,
  output logic               length_ok,
  output logic [BRAND_W-1:0] brand,
  output logic               luhn_ok
);

  luhn_cmd_t    cmd;
  luhn_status_t status;

  luhn_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  luhn_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .pan         (pan),
    .status      (status),
    .digit_count (digit_count),
    .length_ok   (length_ok),
    .brand       (brand),
    .luhn_ok     (luhn_ok)
  );

endmodule
